[rtl/core/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked only while out of reset
`define RFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every edge, reset included
`define RFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/core/rfp_pkg.sv]
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types and constants of the record filter and paginator.
// ----------------------------------------------------------------------------
package rfp_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] REG_AGE_WINDOW     = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_SEX_WANT       = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_MIN_ACTIVE     = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_MIN_PIC        = 8'd3;
  localparam logic [CfgIdxW-1:0] REG_MIN_SINGLE     = 8'd4;
  localparam logic [CfgIdxW-1:0] REG_SEXUALITY_WANT = 8'd5;
  localparam logic [CfgIdxW-1:0] REG_PAGE_OFFSET    = 8'd6;
  localparam logic [CfgIdxW-1:0] REG_ROW_LIMIT      = 8'd7;

  // register reset values
  localparam logic [15:0] AGE_WINDOW_RST     = 16'h3C0E;
  localparam logic [1:0]  SEX_WANT_RST       = 2'd2;
  localparam logic [1:0]  MIN_ACTIVE_RST     = 2'd2;
  localparam logic [1:0]  MIN_PIC_RST        = 2'd1;
  localparam logic        MIN_SINGLE_RST     = 1'b0;
  localparam logic [1:0]  SEXUALITY_WANT_RST = 2'd0;
  localparam logic [31:0] PAGE_OFFSET_RST    = 32'd0;
  localparam logic [15:0] ROW_LIMIT_RST      = 16'd25;

  // wildcard codes
  localparam logic [1:0] SEX_ANY       = 2'd2;
  localparam logic [1:0] SEXUALITY_ANY = 2'd0;

  localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] age_window;
    logic [1:0]  sex_want;
    logic [1:0]  min_active;
    logic [1:0]  min_pic;
    logic        min_single;
    logic [1:0]  sexuality_want;
    logic [31:0] page_offset;
    logic [15:0] row_limit;
  } cfg_t;

  // one queued word of work: a hit, a summary, or both
  typedef struct packed {
    logic [31:0] user_id;
    logic [31:0] total;
    logic        hit;
    logic        done;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/core/rfp_front.sv]
// ----------------------------------------------------------------------------
// rfp_front
// Holds the configuration, tests each record against the predicate and
// updates the match and emit counters; queues one entry per record that
// produces any result.
// ----------------------------------------------------------------------------
module rfp_front #(
  parameter int unsigned STOP_WHEN_FULL = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rfp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rfp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   user_id_i,
  input  logic [7:0]                    age_i,
  input  logic                          sex_code_i,
  input  logic [1:0]                    active_level_i,
  input  logic [1:0]                    pic_level_i,
  input  logic                          single_flag_i,
  input  logic [1:0]                    sexuality_code_i,
  input  logic                          last_record_i,
  input  rfp_pkg::q_status_t            q_status_i,
  output logic                          push_o,
  output rfp_pkg::entry_t               entry_o
);

  rfp_pkg::cfg_t cfg_q, cfg_d;
  logic [31:0]   match_count_q, match_count_d;
  logic [15:0]   emitted_q, emitted_d;
  logic          stopped_q, stopped_d;

  logic          accept;
  logic          pred;
  logic          match;
  logic          hit;
  logic [31:0]   count_upd;
  logic [15:0]   emitted_upd;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !q_status_i.full;
  assign accept      = in_valid_i && in_ready_o;

  // register writes, unknown index ignored
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rfp_pkg::REG_AGE_WINDOW:     cfg_d.age_window     = cfg_data_i[15:0];
        rfp_pkg::REG_SEX_WANT:       cfg_d.sex_want       = cfg_data_i[1:0];
        rfp_pkg::REG_MIN_ACTIVE:     cfg_d.min_active     = cfg_data_i[1:0];
        rfp_pkg::REG_MIN_PIC:        cfg_d.min_pic        = cfg_data_i[1:0];
        rfp_pkg::REG_MIN_SINGLE:     cfg_d.min_single     = cfg_data_i[0];
        rfp_pkg::REG_SEXUALITY_WANT: cfg_d.sexuality_want = cfg_data_i[1:0];
        rfp_pkg::REG_PAGE_OFFSET:    cfg_d.page_offset    = cfg_data_i;
        rfp_pkg::REG_ROW_LIMIT:      cfg_d.row_limit      = cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // record predicate
  always_comb begin
    pred = (age_i >= cfg_q.age_window[7:0]) && (age_i <= cfg_q.age_window[15:8]);
    if (cfg_q.sex_want != rfp_pkg::SEX_ANY && {1'b0, sex_code_i} != cfg_q.sex_want) begin
      pred = 1'b0;
    end
    if (active_level_i < cfg_q.min_active) pred = 1'b0;
    if (pic_level_i < cfg_q.min_pic) pred = 1'b0;
    if (single_flag_i < cfg_q.min_single) pred = 1'b0;
    if (cfg_q.sexuality_want != rfp_pkg::SEXUALITY_ANY &&
        sexuality_code_i != cfg_q.sexuality_want) begin
      pred = 1'b0;
    end
  end

  // counter updates and paging decision
  always_comb begin
    match       = !stopped_q && pred;
    count_upd   = match_count_q;
    if (match && match_count_q != rfp_pkg::COUNT_MAX) begin
      count_upd = match_count_q + 32'd1;
    end
    hit         = match && (count_upd > cfg_q.page_offset) &&
                  (emitted_q < cfg_q.row_limit);
    emitted_upd = hit ? emitted_q + 16'd1 : emitted_q;

    match_count_d = match_count_q;
    emitted_d     = emitted_q;
    stopped_d     = stopped_q;
    if (accept) begin
      if (last_record_i) begin
        match_count_d = '0;
        emitted_d     = '0;
        stopped_d     = 1'b0;
      end else begin
        match_count_d = count_upd;
        emitted_d     = emitted_upd;
        if (STOP_WHEN_FULL != 0 && hit && emitted_upd == cfg_q.row_limit) begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  // queue entry
  assign push_o          = accept && (hit || last_record_i);
  assign entry_o.user_id = user_id_i;
  assign entry_o.total   = count_upd;
  assign entry_o.hit     = hit;
  assign entry_o.done    = last_record_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.age_window     <= rfp_pkg::AGE_WINDOW_RST;
      cfg_q.sex_want       <= rfp_pkg::SEX_WANT_RST;
      cfg_q.min_active     <= rfp_pkg::MIN_ACTIVE_RST;
      cfg_q.min_pic        <= rfp_pkg::MIN_PIC_RST;
      cfg_q.min_single     <= rfp_pkg::MIN_SINGLE_RST;
      cfg_q.sexuality_want <= rfp_pkg::SEXUALITY_WANT_RST;
      cfg_q.page_offset    <= rfp_pkg::PAGE_OFFSET_RST;
      cfg_q.row_limit      <= rfp_pkg::ROW_LIMIT_RST;
      match_count_q        <= '0;
      emitted_q            <= '0;
      stopped_q            <= 1'b0;
    end else begin
      cfg_q         <= cfg_d;
      match_count_q <= match_count_d;
      emitted_q     <= emitted_d;
      stopped_q     <= stopped_d;
    end
  end

endmodule

[rtl/core/rfp_queue.sv]
// ----------------------------------------------------------------------------
// rfp_queue
// Short first-in first-out queue of work entries between front and back.
// ----------------------------------------------------------------------------
module rfp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rfp_pkg::entry_t    entry_i,
  input  logic               pop_i,
  output rfp_pkg::entry_t    head_o,
  output rfp_pkg::q_status_t status_o
);

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  rfp_pkg::entry_t   store_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              do_push;
  logic              do_pop;

  assign status_o.full  = (count_q == CntW'(DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = store_q[rd_ptr_q];

  // pointer and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

[rtl/core/rfp_back.sv]
// ----------------------------------------------------------------------------
// rfp_back
// Takes queued entries and sends result words one per cycle while the output
// is ready, through an output register: hit word first, then summary word.
// ----------------------------------------------------------------------------
module rfp_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rfp_pkg::q_status_t q_status_i,
  input  rfp_pkg::entry_t    head_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [31:0]        hit_id_o,
  output logic [31:0]        total_matches_o,
  output logic               done_res_o
);

  logic        cur_hit_q, cur_hit_d;
  logic        cur_done_q, cur_done_d;
  logic [31:0] cur_id_q;
  logic [31:0] cur_total_q;
  logic        out_valid_q, out_valid_d;
  logic [31:0] hit_id_q;
  logic [31:0] total_q;
  logic        done_q;

  logic        out_free;
  logic        emit;
  logic        hit_left;
  logic        done_left;

  assign out_free = !out_valid_q || out_ready_i;
  assign emit     = out_free && (cur_hit_q || cur_done_q);

  // pending words of the current entry, refill when it drains
  always_comb begin
    hit_left   = cur_hit_q && !emit;
    done_left  = cur_done_q && !(emit && !cur_hit_q);
    pop_o      = !q_status_i.empty && !(hit_left || done_left);
    cur_hit_d  = pop_o ? head_i.hit  : hit_left;
    cur_done_d = pop_o ? head_i.done : done_left;
  end

  // output register
  always_comb begin
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_hit_q   <= 1'b0;
      cur_done_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cur_hit_q   <= cur_hit_d;
      cur_done_q  <= cur_done_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_id_q    <= head_i.user_id;
      cur_total_q <= head_i.total;
    end
    if (emit) begin
      hit_id_q <= cur_hit_q ? cur_id_q : 32'd0;
      total_q  <= cur_total_q;
      done_q   <= !cur_hit_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign hit_id_o        = hit_id_q;
  assign total_matches_o = total_q;
  assign done_res_o      = done_q;

endmodule

[rtl/core/record_filter_paginator_core.sv]
// ----------------------------------------------------------------------------
// record_filter_paginator_core
// Streaming profile filter with a saturating match total and page output.
// ----------------------------------------------------------------------------
// Takes one record per cycle. Each record is tested in the cycle it is
// accepted and the counters update at once, so records may follow back to
// back. Results leave one word per cycle, stalled by output ready, from the
// queue via the current-entry registers and an output register; a hit that
// is last of its scan gives a hit word and a summary word. A queue of
// QUEUE_DEPTH entries between the classifier and the output stage absorbs
// those bursts and output stalls; input ready drops only when it is full.
// Configuration writes are taken every cycle and are meant for idle periods.
module record_filter_paginator_core #(
  parameter int unsigned STOP_WHEN_FULL = 0,
  parameter int unsigned QUEUE_DEPTH    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rfp_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [rfp_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [31:0]                   user_id_i,
  input  logic [7:0]                    age_i,
  input  logic                          sex_code_i,
  input  logic [1:0]                    active_level_i,
  input  logic [1:0]                    pic_level_i,
  input  logic                          single_flag_i,
  input  logic [1:0]                    sexuality_code_i,
  input  logic                          last_record_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [31:0]                   hit_id_o,
  output logic [31:0]                   total_matches_o,
  output logic                          done_res_o
);

  rfp_pkg::q_status_t q_status;
  rfp_pkg::entry_t    push_entry;
  rfp_pkg::entry_t    head_entry;
  logic               push;
  logic               pop;

  // classifier and counters
  rfp_front #(
    .STOP_WHEN_FULL (STOP_WHEN_FULL)
  ) u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .user_id_i        (user_id_i),
    .age_i            (age_i),
    .sex_code_i       (sex_code_i),
    .active_level_i   (active_level_i),
    .pic_level_i      (pic_level_i),
    .single_flag_i    (single_flag_i),
    .sexuality_code_i (sexuality_code_i),
    .last_record_i    (last_record_i),
    .q_status_i       (q_status),
    .push_o           (push),
    .entry_o          (push_entry)
  );

  // work queue
  rfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head_entry),
    .status_o (q_status)
  );

  // result sequencer
  rfp_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_status_i      (q_status),
    .head_i          (head_entry),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .hit_id_o        (hit_id_o),
    .total_matches_o (total_matches_o),
    .done_res_o      (done_res_o)
  );

endmodule

[rtl/core/rfp_checker.sv]
// ----------------------------------------------------------------------------
// rfp_checker
// Port-level checks of the record filter and paginator, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rfp_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [31:0]                   hit_id_o,
  input logic [31:0]                   total_matches_o,
  input logic                          done_res_o
);

  // a result word stays offered until taken
  `RFP_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result word dropped")

  // nothing offered while in reset
  `RFP_ASSERT_ALWAYS(a_rst_quiet, !rst_ni |-> !out_valid_o, "result offered in reset")

  // a summary word carries no user id
  `RFP_ASSERT(a_done_id, out_valid_o && done_res_o |-> hit_id_o == 32'd0, "summary with id")

  // a hit always follows at least one counted match
  `RFP_ASSERT(a_hit_total, out_valid_o && !done_res_o |-> total_matches_o != 32'd0, "hit with zero total")

endmodule

bind record_filter_paginator_core rfp_checker u_rfp_checker (.*);

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for record_filter_paginator_core.
// ----------------------------------------------------------------------------
// A table of hand-picked records and register writes comes first: window
// edges, every predicate field, wildcard and never-match codes, an empty age
// window, zero and maximal row limits and page offsets, and ignored register
// indexes. Random scans then run under several idling mixes and random
// settings, plus a stretch where the output is held off so the block backs
// up. Output words are checked against typed rows or a model of the filter.
// ----------------------------------------------------------------------------
module tb_top;

  import rfp_pkg::*;

  localparam int unsigned CLK_HALF       = 6;
  localparam int unsigned STOP_FULL      = 0;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned HOLD_CYCLES    = 200;
  localparam int unsigned TIMEOUT_CYCLES = 300000;

  // indexes that decode to no register
  localparam logic [CfgIdxW-1:0] REG_OUT_OF_RANGE = 8'd8;
  localparam logic [CfgIdxW-1:0] REG_TOP_INDEX    = 8'hFF;

  typedef struct packed {
    logic [31:0] user_id;
    logic [7:0]  age;
    logic        sex;
    logic [1:0]  active;
    logic [1:0]  pic;
    logic        single;
    logic [1:0]  sexuality;
    logic        last;
  } profile_t;

  typedef struct packed {
    logic [31:0] hit_id;
    logic [31:0] total;
    logic        done;
  } page_word_t;

  typedef enum logic {ROW_RECORD, ROW_REG_WRITE} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CfgDataW-1:0] reg_data;
    profile_t            rec;
    logic                typed;
    logic                want_hit;
    logic                want_done;
    logic [31:0]         want_id;
    logic [31:0]         want_total;
  } step_t;

  // clock and reset
  logic clk_i = 1'b0;
  logic rst_ni;

  always begin
    #(CLK_HALF) clk_i = 1'b1;
    #(CLK_HALF) clk_i = 1'b0;
  end

  // block inputs, all known from time zero
  logic                cfg_valid = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;
  logic                in_valid  = 1'b0;
  profile_t            in_rec    = '0;
  logic                out_ready = 1'b0;
  logic                out_hold  = 1'b0;

  logic        cfg_ready_o;
  logic        in_ready_o;
  logic        out_valid_o;
  logic [31:0] hit_id_o;
  logic [31:0] total_matches_o;
  logic        done_res_o;

  record_filter_paginator_core #(
    .STOP_WHEN_FULL(STOP_FULL)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready_o),
    .user_id_i       (in_rec.user_id),
    .age_i           (in_rec.age),
    .sex_code_i      (in_rec.sex),
    .active_level_i  (in_rec.active),
    .pic_level_i     (in_rec.pic),
    .single_flag_i   (in_rec.single),
    .sexuality_code_i(in_rec.sexuality),
    .last_record_i   (in_rec.last),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready),
    .hit_id_o        (hit_id_o),
    .total_matches_o (total_matches_o),
    .done_res_o      (done_res_o)
  );

  // shadow of the filter settings and scan state
  cfg_t        setting = '{age_window: AGE_WINDOW_RST, sex_want: SEX_WANT_RST,
                           min_active: MIN_ACTIVE_RST, min_pic: MIN_PIC_RST,
                           min_single: MIN_SINGLE_RST,
                           sexuality_want: SEXUALITY_WANT_RST,
                           page_offset: PAGE_OFFSET_RST, row_limit: ROW_LIMIT_RST};
  logic [31:0] match_total = '0;
  logic [15:0] emitted     = '0;
  logic        frozen      = 1'b0;

  page_word_t  pending[$];
  step_t       dir_rows[$];
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned scan_left      = 0;
  int unsigned records_sent   = 0;
  int unsigned reg_writes     = 0;
  int unsigned hits_seen      = 0;
  int unsigned summaries_seen = 0;
  int unsigned mismatches     = 0;

  // append one expected word
  function automatic void queue_word(input page_word_t w);
    pending = {pending, w};
  endfunction

  // append one row of the directed table
  function automatic void add_row(input step_t s);
    dir_rows = {dir_rows, s};
  endfunction

  // filter one record, update scan state, return the words it causes
  function automatic int unsigned filter_record(input profile_t r,
                                                output page_word_t w0,
                                                output page_word_t w1);
    page_word_t  w [2];
    int unsigned n;
    logic        hit_now;
    n    = 0;
    w[0] = '0;
    w[1] = '0;
    hit_now = !frozen
      && r.age >= setting.age_window[7:0] && r.age <= setting.age_window[15:8]
      && (setting.sex_want == SEX_ANY || {1'b0, r.sex} == setting.sex_want)
      && r.active >= setting.min_active
      && r.pic >= setting.min_pic
      && r.single >= setting.min_single
      && (setting.sexuality_want == SEXUALITY_ANY
          || r.sexuality == setting.sexuality_want);
    if (hit_now) begin
      if (match_total != COUNT_MAX) match_total = match_total + 32'd1;
      if (match_total > setting.page_offset && emitted < setting.row_limit) begin
        w[n] = '{hit_id: r.user_id, total: match_total, done: 1'b0};
        n++;
        emitted = emitted + 16'd1;
        if (STOP_FULL != 0 && emitted == setting.row_limit) frozen = 1'b1;
      end
    end
    // closing summary word, then a fresh scan
    if (r.last) begin
      w[n] = '{hit_id: 32'd0, total: match_total, done: 1'b1};
      n++;
      match_total = '0;
      emitted     = '0;
      frozen      = 1'b0;
    end
    w0 = w[0];
    w1 = w[1];
    return n;
  endfunction

  // random record: mostly built to pass the current predicate
  function automatic profile_t next_record();
    profile_t r;
    logic     noise;
    r         = '0;
    r.user_id = $urandom();
    noise = ($urandom_range(99) >= 80)
            || (setting.age_window[7:0] > setting.age_window[15:8]);
    if (!noise) begin
      r.age       = 8'($urandom_range(setting.age_window[15:8], setting.age_window[7:0]));
      r.sex       = (setting.sex_want < SEX_ANY) ? setting.sex_want[0]
                                                 : 1'($urandom_range(1));
      r.active    = 2'($urandom_range(3, setting.min_active));
      r.pic       = 2'($urandom_range(3, setting.min_pic));
      r.single    = setting.min_single ? 1'b1 : 1'($urandom_range(1));
      r.sexuality = (setting.sexuality_want != SEXUALITY_ANY) ? setting.sexuality_want
                                                              : 2'($urandom_range(3));
    end else begin
      {r.age, r.sex, r.active, r.pic, r.single, r.sexuality} = 16'($urandom());
    end
    // scan framing, with the odd early end among the noise
    if (noise && $urandom_range(19) == 0) scan_left = 1;
    if (scan_left == 0) scan_left = ($urandom_range(9) == 0) ? 1 : $urandom_range(40, 2);
    scan_left--;
    r.last = (scan_left == 0);
    return r;
  endfunction

  function automatic profile_t prof(input logic [31:0] id, input logic [7:0] age,
                                    input logic sex, input logic [1:0] act,
                                    input logic [1:0] pic, input logic sgl,
                                    input logic [1:0] sxl, input logic last);
    prof = '{user_id: id, age: age, sex: sex, active: act, pic: pic,
             single: sgl, sexuality: sxl, last: last};
  endfunction

  function automatic step_t reg_row(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] data);
    reg_row          = '0;
    reg_row.kind     = ROW_REG_WRITE;
    reg_row.reg_idx  = idx;
    reg_row.reg_data = data;
  endfunction

  function automatic step_t open_row(input profile_t r);
    open_row      = '0;
    open_row.kind = ROW_RECORD;
    open_row.rec  = r;
  endfunction

  function automatic step_t typed_row(input profile_t r, input logic want_hit,
                                      input logic want_done, input logic [31:0] want_id,
                                      input logic [31:0] want_total);
    typed_row            = open_row(r);
    typed_row.typed      = 1'b1;
    typed_row.want_hit   = want_hit;
    typed_row.want_done  = want_done;
    typed_row.want_id    = want_id;
    typed_row.want_total = want_total;
  endfunction

  // offer one record word and wait for it to be taken
  task automatic send_record(input profile_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_rec   <= r;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    records_sent++;
  endtask

  task automatic issue_record(input profile_t r);
    page_word_t  w0, w1;
    int unsigned n;
    send_record(r);
    n = filter_record(r, w0, w1);
    if (n > 0) queue_word(w0);
    if (n > 1) queue_word(w1);
  endtask

  // register write, mirrored into the shadow settings
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid <= 1'b0;
    reg_writes++;
    case (idx)
      REG_AGE_WINDOW:     setting.age_window     = data[15:0];
      REG_SEX_WANT:       setting.sex_want       = data[1:0];
      REG_MIN_ACTIVE:     setting.min_active     = data[1:0];
      REG_MIN_PIC:        setting.min_pic        = data[1:0];
      REG_MIN_SINGLE:     setting.min_single     = data[0];
      REG_SEXUALITY_WANT: setting.sexuality_want = data[1:0];
      REG_PAGE_OFFSET:    setting.page_offset    = data;
      REG_ROW_LIMIT:      setting.row_limit      = data[15:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // stop sending, let every expected word out, then let the pipe empty
  task automatic settle();
    in_valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_random_setting();
    logic [7:0]  lo, hi;
    int unsigned pick;
    pick = $urandom_range(9);
    lo   = 8'($urandom_range(40));
    hi   = 8'(lo + $urandom_range(120));
    if (pick == 0) begin
      lo = 8'd0;
      hi = 8'd255;
    end else if (pick == 3) begin
      lo = 8'd200;
      hi = 8'd100;
    end
    write_reg(REG_AGE_WINDOW, {16'd0, hi, lo});
    write_reg(REG_SEX_WANT, ($urandom_range(9) == 0) ? 32'd3 : $urandom_range(2));
    write_reg(REG_MIN_ACTIVE, $urandom_range(3));
    write_reg(REG_MIN_PIC, $urandom_range(3));
    write_reg(REG_MIN_SINGLE, $urandom_range(1));
    write_reg(REG_SEXUALITY_WANT, $urandom_range(3));
    write_reg(REG_PAGE_OFFSET, (pick == 1) ? $urandom() : $urandom_range(12));
    write_reg(REG_ROW_LIMIT, (pick == 2) ? 32'h0000_FFFF : $urandom_range(30));
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (2) begin
      settle();
      load_random_setting();
      repeat (100) issue_record(next_record());
    end
  endtask

  // long output hold-off, counted here while the sender carries on
  task automatic hold_output(input int unsigned cycles);
    out_hold <= 1'b1;
    repeat (cycles) @(posedge clk_i);
    out_hold <= 1'b0;
  endtask

  // receiver ready with random stalls
  always @(posedge clk_i) begin
    out_ready <= !out_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // output word checker
  always @(posedge clk_i) begin : word_check
    page_word_t want;
    if (rst_ni && out_valid_o && out_ready) begin
      if (pending.size() == 0) begin
        $display("%0t: output word with none expected: id %h total %h done %b",
                 $time, hit_id_o, total_matches_o, done_res_o);
        mismatches++;
      end else begin
        want = pending.pop_front();
        if (hit_id_o !== want.hit_id) begin
          $display("%0t: hit_id expected %h actual %h", $time, want.hit_id, hit_id_o);
          mismatches++;
        end
        if (total_matches_o !== want.total) begin
          $display("%0t: total_matches expected %h actual %h",
                   $time, want.total, total_matches_o);
          mismatches++;
        end
        if (done_res_o !== want.done) begin
          $display("%0t: done_res expected %b actual %b", $time, want.done, done_res_o);
          mismatches++;
        end
        if (want.done) summaries_seen++;
        else hits_seen++;
      end
    end
  end

  // watchdog
  initial begin
    #(2 * CLK_HALF * TIMEOUT_CYCLES);
    $display("%0t: run timed out with %0d words still expected", $time, pending.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : main_flow
    page_word_t  w0, w1;
    int unsigned n;

    // reset falls at time zero so the asynchronous reset takes hold at once
    rst_ni <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: ages 14 to 60, any sex, activity 2+, picture 1+
    add_row(typed_row(prof(32'hFFFF_FFFF, 14, 0, 2, 1, 0, 0, 0),
                      1, 0, 32'hFFFF_FFFF, 1));
    add_row(typed_row(prof(32'd0, 60, 1, 3, 3, 1, 3, 0), 1, 0, 32'd0, 2));
    add_row(typed_row(prof(32'h1234_5678, 13, 0, 3, 3, 1, 2, 0), 0, 0, 0, 0));
    add_row(typed_row(prof(32'h8765_4321, 61, 1, 3, 3, 0, 1, 0), 0, 0, 0, 0));
    add_row(typed_row(prof(32'd3, 30, 0, 1, 3, 1, 0, 0), 0, 0, 0, 0));
    add_row(typed_row(prof(32'd4, 30, 1, 3, 0, 0, 2, 0), 0, 0, 0, 0));
    add_row(typed_row(prof(32'd5, 255, 1, 3, 3, 1, 3, 0), 0, 0, 0, 0));
    add_row(typed_row(prof(32'hA5A5_5A5A, 40, 1, 2, 2, 1, 1, 1),
                      1, 1, 32'hA5A5_5A5A, 3));
    add_row(typed_row(prof(32'd6, 0, 0, 0, 0, 0, 0, 1), 0, 1, 0, 0));
    // sex code three never matches
    add_row(reg_row(REG_AGE_WINDOW, 32'h0000_FF00));
    add_row(reg_row(REG_SEX_WANT, 32'd3));
    add_row(reg_row(REG_MIN_ACTIVE, 32'd0));
    add_row(reg_row(REG_MIN_PIC, 32'd0));
    add_row(reg_row(REG_MIN_SINGLE, 32'd1));
    add_row(reg_row(REG_SEXUALITY_WANT, 32'd3));
    add_row(typed_row(prof(32'd7, 0, 1, 0, 0, 1, 3, 1), 0, 1, 0, 0));
    // exact sex and sexuality match
    add_row(reg_row(REG_SEX_WANT, 32'd1));
    add_row(reg_row(REG_MIN_SINGLE, 32'd0));
    add_row(reg_row(REG_SEXUALITY_WANT, 32'd2));
    add_row(open_row(prof(32'h0F0F_F0F0, 200, 1, 0, 0, 0, 2, 0)));
    add_row(open_row(prof(32'd8, 200, 0, 0, 0, 0, 2, 0)));
    add_row(open_row(prof(32'd9, 200, 1, 0, 0, 0, 1, 0)));
    // empty window mid-scan; writes to unknown indexes must not land
    add_row(reg_row(REG_AGE_WINDOW, 32'h0000_1020));
    add_row(reg_row(REG_OUT_OF_RANGE, 32'h0000_FF00));
    add_row(open_row(prof(32'd10, 20, 1, 3, 3, 1, 2, 1)));
    // zero row limit: counted but never emitted
    add_row(reg_row(REG_AGE_WINDOW, 32'h0000_FFFF));
    add_row(reg_row(REG_ROW_LIMIT, 32'd0));
    add_row(reg_row(REG_SEX_WANT, SEX_ANY));
    add_row(reg_row(REG_SEXUALITY_WANT, SEXUALITY_ANY));
    add_row(open_row(prof(32'd11, 255, 0, 0, 0, 0, 0, 0)));
    add_row(open_row(prof(32'd12, 254, 0, 0, 0, 0, 0, 1)));
    // page of two after one skipped match
    add_row(reg_row(REG_AGE_WINDOW, 32'h0000_FF00));
    add_row(reg_row(REG_ROW_LIMIT, 32'd2));
    add_row(reg_row(REG_PAGE_OFFSET, 32'd1));
    add_row(reg_row(REG_TOP_INDEX, 32'hFFFF_FFFF));
    for (int i = 0; i < 5; i++)
      add_row(open_row(prof(32'd13 + i, 8'(37 * i), i[0], 0, 0, 0, 2'(i), i == 4)));
    // offset at its maximum hides every match
    add_row(reg_row(REG_PAGE_OFFSET, 32'hFFFF_FFFF));
    add_row(reg_row(REG_ROW_LIMIT, 32'h0000_FFFF));
    add_row(open_row(prof(32'd20, 100, 1, 1, 2, 1, 3, 0)));
    add_row(open_row(prof(32'd21, 101, 0, 2, 1, 0, 1, 1)));
    add_row(reg_row(REG_PAGE_OFFSET, 32'd0));
    add_row(open_row(prof(32'hFFFF_FFFF, 255, 1, 3, 3, 1, 3, 1)));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG_WRITE) begin
        settle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      end else if (dir_rows[i].typed) begin
        send_record(dir_rows[i].rec);
        n = filter_record(dir_rows[i].rec, w0, w1);
        if (dir_rows[i].want_hit)
          queue_word('{hit_id: dir_rows[i].want_id,
                       total: dir_rows[i].want_total, done: 1'b0});
        if (dir_rows[i].want_done)
          queue_word('{hit_id: 32'd0, total: dir_rows[i].want_total, done: 1'b1});
      end else begin
        issue_record(dir_rows[i].rec);
      end
    end

    // back-pressure: everything matches while the output is held off
    settle();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    write_reg(REG_AGE_WINDOW, 32'h0000_FF00);
    write_reg(REG_SEX_WANT, SEX_ANY);
    write_reg(REG_MIN_ACTIVE, 32'd0);
    write_reg(REG_MIN_PIC, 32'd0);
    write_reg(REG_MIN_SINGLE, 32'd0);
    write_reg(REG_SEXUALITY_WANT, SEXUALITY_ANY);
    write_reg(REG_PAGE_OFFSET, 32'd0);
    write_reg(REG_ROW_LIMIT, 32'h0000_FFFF);
    fork
      hold_output(HOLD_CYCLES);
      repeat (60) issue_record(next_record());
    join

    // random scans under each idling mix
    run_phase(0, 0);
    run_phase(88, 0);
    run_phase(0, 88);
    run_phase(11, 11);
    settle();

    $display("covered %0d records and %0d register writes under four idling mixes",
             records_sent, reg_writes);
    $display("checked %0d hit words and %0d scan summaries, %0d mismatches",
             hits_seen, summaries_seen, mismatches);
    if (mismatches == 0 && pending.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
